// ----- rtl/itq_pkg.sv -----
// Shared types, constants and helper functions for the infix to quadruple translator.
// No dependencies; every other file in rtl imports this package.
package itq_pkg;

  localparam int StackDepth = 32;
  localparam int StkAw      = $clog2(StackDepth);
  localparam int StkCw      = $clog2(StackDepth + 1);
  localparam int MaxResults = 33;
  localparam int CntW       = $clog2(MaxResults + 1);

  localparam logic [2:0] OpPlus   = 3'd0;
  localparam logic [2:0] OpMinus  = 3'd1;
  localparam logic [2:0] OpTimes  = 3'd2;
  localparam logic [2:0] OpDivide = 3'd3;
  localparam logic [2:0] OpPower  = 3'd4;
  localparam logic [2:0] OpOpen   = 3'd5;  // '(' on the operator stack
  localparam logic [2:0] OpAssign = 3'd5;  // '=' in a quadruple

  localparam logic [1:0] KindVar  = 2'd0;
  localparam logic [1:0] KindTemp = 2'd1;
  localparam logic [1:0] KindNone = 2'd2;

  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChTimes  = 8'h2A;
  localparam logic [7:0] ChDivide = 8'h2F;
  localparam logic [7:0] ChPower  = 8'h5E;
  localparam logic [7:0] ChOpen   = 8'h28;
  localparam logic [7:0] ChClose  = 8'h29;
  localparam logic [7:0] ChEqual  = 8'h3D;

  typedef struct packed {
    logic [2:0] op;
    logic       a1_kind;
    logic [7:0] a1_value;
    logic [1:0] a2_kind;
    logic [7:0] a2_value;
    logic       d_kind;
    logic [7:0] d_value;
    logic       err;
    logic       eoe;
  } quad_t;

  // One classified input step: up to two characters to process, then optional flush.
  typedef struct packed {
    logic       proc0;
    logic [7:0] ch0;
    logic       proc1;
    logic [7:0] ch1;
    logic       flush;
    logic       assign_v;
    logic [7:0] target;
  } step_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // {valid, code}
  function automatic logic [3:0] op_code(input logic [7:0] c);
    logic [3:0] r;
    r = 4'd0;
    unique case (c)
      ChPlus:   r = {1'b1, OpPlus};
      ChMinus:  r = {1'b1, OpMinus};
      ChTimes:  r = {1'b1, OpTimes};
      ChDivide: r = {1'b1, OpDivide};
      ChPower:  r = {1'b1, OpPower};
      ChOpen:   r = {1'b1, OpOpen};
      default:  r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] prio_stack(input logic [2:0] code);
    logic [2:0] r;
    r = 3'd0;
    unique case (code)
      OpPlus, OpMinus:   r = 3'd1;
      OpTimes, OpDivide: r = 3'd2;
      OpPower:           r = 3'd3;
      default:           r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] prio_in(input logic [2:0] code);
    logic [2:0] r;
    r = 3'd0;
    unique case (code)
      OpPlus, OpMinus:   r = 3'd1;
      OpTimes, OpDivide: r = 3'd2;
      default:           r = 3'd4;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/infix_to_quadruple_translator.sv -----
// Top level of the infix to quadruple translator: front, step queue and back.
// Depends on itq_pkg, itq_front, itq_queue and itq_back.
//
// Feed an infix expression one ASCII character per request on the slave stream,
// tlast set on its final character. Letters are operands; + - * / ^ ( ) are
// operators, ^ binds right to left, and everything else is ignored. If the
// second character is '=' after a letter, that letter receives the result through
// a final assign quadruple. Each reduction leaves on the master stream as one
// quadruple, tlast marking the final quadruple of the expression; tuser carries a
// sticky error flag for stack overflow or underflow within the expression.
// Timing: the front takes one character per cycle into a two-step queue while
// the queue has room; the first character of an expression is held in the front.
// The back handles every step as a queue pop, three processing slots and an end
// of step. An operator or parenthesis adds a stack decision, each reduction pops
// the operator and then the two operands, and a flush pops every stacked operator,
// discarding each '(', before any assign quadruple. A stalled master stream holds
// the back at its next quadruple.
// Both stacks are 32 deep; at most 33 quadruples are reported per step.
module infix_to_quadruple_translator import itq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] op, [3] arg1_kind, [11:4] arg1_value, [13:12] arg2_kind,
  // [21:14] arg2_value, [22] dest_kind, [30:23] dest_value, [31] zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] error
  output logic        m_axis_tlast    // end of expression
);

  logic  push, full, empty, pop;
  step_t step_in, step_out;
  quad_t quad;

  itq_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ch_i    (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .step_o     (step_in),
    .full_i     (full)
  );

  itq_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (step_in),
    .pop_i   (pop),
    .data_o  (step_out),
    .full_o  (full),
    .empty_o (empty)
  );

  itq_back u_back (
    .clk_i, .rst_ni,
    .empty_i     (empty),
    .step_i      (step_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_o       (quad),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, quad.d_value, quad.d_kind, quad.a2_value, quad.a2_kind,
                         quad.a1_value, quad.a1_kind, quad.op};
  assign m_axis_tuser = quad.err;
  assign m_axis_tlast = quad.eoe;

endmodule

// ----- rtl/itq_front.sv -----
// Front end: accepts characters, tracks position and assignment prefix, builds steps.
// Depends on itq_pkg.
module itq_front import itq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_ch_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  output logic       push_o,
  output step_t      step_o,
  input  logic       full_i
);

  logic [1:0] pos_q, pos_d;
  logic [7:0] held_q, held_d;
  logic       asg_q, asg_d;
  logic [7:0] tgt_q, tgt_d;
  logic       acc;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && !full_i;
  assign push_o     = acc && (pos_q != 2'd0 || in_last_i);

  always_comb begin
    pos_d  = pos_q;
    held_d = held_q;
    asg_d  = asg_q;
    tgt_d  = tgt_q;
    step_o = '{proc0: 1'b0, ch0: in_ch_i, proc1: 1'b0, ch1: in_ch_i,
               flush: in_last_i, assign_v: asg_q, target: tgt_q};
    if (pos_q == 2'd0) begin
      step_o.proc0 = 1'b1;
      held_d       = in_ch_i;
      pos_d        = 2'd1;
    end else if (pos_q == 2'd1) begin
      if (in_ch_i == ChEqual && is_letter(held_q)) begin
        asg_d           = 1'b1;
        tgt_d           = held_q;
        step_o.assign_v = 1'b1;
        step_o.target   = held_q;
      end else begin
        step_o.proc0 = 1'b1;
        step_o.ch0   = held_q;
        step_o.proc1 = 1'b1;
      end
      pos_d = 2'd2;
    end else begin
      step_o.proc0 = 1'b1;
    end
    if (in_last_i) begin
      pos_d  = 2'd0;
      held_d = 8'd0;
      asg_d  = 1'b0;
      tgt_d  = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      held_q <= 8'd0;
      asg_q  <= 1'b0;
      tgt_q  <= 8'd0;
    end else if (acc) begin
      pos_q  <= pos_d;
      held_q <= held_d;
      asg_q  <= asg_d;
      tgt_q  <= tgt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q != 2'd3)
    else $error("front position out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_last_i) |=> (pos_q == 2'd0 && !asg_q))
    else $error("front not cleared after last character");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |-> !full_i)
    else $error("push into full queue");

endmodule

// ----- rtl/itq_queue.sv -----
// Two-entry queue of classified steps between front and back.
// Depends on itq_pkg.
module itq_queue import itq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  step_t data_i,
  input  logic  pop_i,
  output step_t data_o,
  output logic  full_o,
  output logic  empty_o
);

  step_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o)
    else $error("queue lost a request");

endmodule

// ----- rtl/itq_back.sv -----
// Back end: operator and operand stacks, reductions, quadruple output buffering.
// Depends on itq_pkg.
module itq_back import itq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  empty_i,
  input  step_t step_i,
  output logic  pop_o,
  output logic  out_valid_o,
  output quad_t out_o,
  input  logic  out_ready_i
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SNext  = 4'd1;
  localparam logic [3:0] SClose = 4'd2;
  localparam logic [3:0] SPrio  = 4'd3;
  localparam logic [3:0] SFlush = 4'd4;
  localparam logic [3:0] SRedB  = 4'd5;
  localparam logic [3:0] SRedA  = 4'd6;
  localparam logic [3:0] SAsgn  = 4'd7;
  localparam logic [3:0] SEnd   = 4'd8;

  logic [3:0]  st_q, st_d, ret_q, ret_d;
  logic [1:0]  ph_q, ph_d;
  step_t       cur_q;
  logic [2:0]  code_q, code_d, rop_q, rop_d;
  logic [8:0]  b_q, b_d;

  logic [2:0]  ops_q [StackDepth];
  logic [8:0]  opn_q [StackDepth];
  logic [StkCw-1:0] otop_q, otop_d, ntop_q, ntop_d;
  logic [StkCw-1:0] otop_m1, ntop_m1, ntop_pa;
  logic [2:0]  otop_val;
  logic [8:0]  ntop_val;

  logic        ow_en, nw_en;
  logic [StkAw-1:0] ow_idx, nw_idx;
  logic [2:0]  ow_dat;
  logic [8:0]  nw_dat;

  logic [7:0]  temp_q, temp_d;
  logic        err_q, err_d;
  logic [CntW-1:0] cnt_q;
  quad_t       pend_q, out_q, emit_dat;
  logic        pend_v_q, out_v_q, emit_v, can_emit, release_v, release_eoe;

  logic [7:0]  ch;
  logic [3:0]  opc;
  logic        uf;

  assign otop_m1  = otop_q - 1'b1;
  assign ntop_m1  = ntop_q - 1'b1;
  assign otop_val = ops_q[otop_m1[StkAw-1:0]];
  assign ntop_val = opn_q[ntop_m1[StkAw-1:0]];
  assign uf       = ntop_q == '0;
  assign ntop_pa  = uf ? ntop_q : ntop_m1;
  assign can_emit = !pend_v_q || !out_v_q || out_ready_i;
  assign ch       = (ph_q == 2'd0) ? cur_q.ch0 : cur_q.ch1;
  assign opc      = op_code(ch);
  assign pop_o    = (st_q == SIdle) && !empty_i;
  assign out_valid_o = out_v_q;
  assign out_o    = out_q;

  always_comb begin
    st_d = st_q; ret_d = ret_q; ph_d = ph_q; code_d = code_q; rop_d = rop_q; b_d = b_q;
    otop_d = otop_q; ntop_d = ntop_q; temp_d = temp_q; err_d = err_q;
    ow_en = 1'b0; ow_idx = otop_q[StkAw-1:0]; ow_dat = code_q;
    nw_en = 1'b0; nw_idx = ntop_q[StkAw-1:0]; nw_dat = {1'b0, ch};
    emit_v = 1'b0; emit_dat = '0; release_v = 1'b0; release_eoe = 1'b0;
    unique case (st_q)
      SIdle: if (!empty_i) st_d = SNext;
      SNext: begin
        if (ph_q == 2'd2) begin
          st_d = cur_q.flush ? SFlush : SEnd;
        end else if ((ph_q == 2'd0 && cur_q.proc0) || (ph_q == 2'd1 && cur_q.proc1)) begin
          ph_d = ph_q + 2'd1;
          if (is_letter(ch)) begin
            if (ntop_q < StkCw'(StackDepth)) begin
              nw_en  = 1'b1;
              ntop_d = ntop_q + 1'b1;
            end else begin
              err_d = 1'b1;
            end
          end else if (ch == ChClose) begin
            st_d = SClose;
          end else if (opc[3]) begin
            code_d = opc[2:0];
            st_d   = SPrio;
          end
        end else begin
          ph_d = ph_q + 2'd1;
        end
      end
      SClose: begin
        if (otop_q == '0) begin
          st_d = SNext;
        end else begin
          otop_d = otop_m1;
          if (otop_val == OpOpen) begin
            st_d = SNext;
          end else begin
            rop_d = otop_val; ret_d = SClose; st_d = SRedB;
          end
        end
      end
      SPrio: begin
        if (otop_q != '0 && prio_stack(otop_val) >= prio_in(code_q)) begin
          otop_d = otop_m1; rop_d = otop_val; ret_d = SPrio; st_d = SRedB;
        end else begin
          if (otop_q < StkCw'(StackDepth)) begin
            ow_en  = 1'b1;
            otop_d = otop_q + 1'b1;
          end else begin
            err_d = 1'b1;
          end
          st_d = SNext;
        end
      end
      SFlush: begin
        if (otop_q != '0) begin
          otop_d = otop_m1;
          if (otop_val != OpOpen) begin
            rop_d = otop_val; ret_d = SFlush; st_d = SRedB;
          end
        end else begin
          st_d = cur_q.assign_v ? SAsgn : SEnd;
        end
      end
      SRedB: begin
        b_d    = uf ? 9'd0 : ntop_val;
        ntop_d = ntop_pa;
        if (uf) err_d = 1'b1;
        st_d = SRedA;
      end
      SRedA: begin
        if (can_emit) begin
          emit_v   = 1'b1;
          emit_dat = '{op: rop_q, a1_kind: !uf && ntop_val[8], a1_value: uf ? 8'd0 : ntop_val[7:0],
                       a2_kind: {1'b0, b_q[8]}, a2_value: b_q[7:0], d_kind: 1'b1,
                       d_value: temp_q, err: err_q | uf, eoe: 1'b0};
          err_d  = err_q | uf;
          nw_idx = ntop_pa[StkAw-1:0];
          nw_dat = {1'b1, temp_q};
          if (ntop_pa < StkCw'(StackDepth)) begin
            nw_en  = 1'b1;
            ntop_d = ntop_pa + 1'b1;
          end else begin
            ntop_d = ntop_pa;
            err_d  = 1'b1;
          end
          temp_d = temp_q + 8'd1;
          st_d   = ret_q;
        end
      end
      SAsgn: begin
        if (can_emit) begin
          emit_v   = 1'b1;
          emit_dat = '{op: OpAssign, a1_kind: !uf && ntop_val[8],
                       a1_value: uf ? 8'd0 : ntop_val[7:0], a2_kind: KindNone, a2_value: 8'd0,
                       d_kind: 1'b0, d_value: cur_q.target, err: err_q | uf, eoe: 1'b0};
          err_d  = err_q | uf;
          ntop_d = ntop_pa;
          st_d   = SEnd;
        end
      end
      SEnd: begin
        if (!pend_v_q || !out_v_q || out_ready_i) begin
          release_v   = pend_v_q;
          release_eoe = cur_q.flush;
          if (cur_q.flush) begin
            otop_d = '0; ntop_d = '0; temp_d = 8'd0; err_d = 1'b0;
          end
          st_d = SIdle;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ow_en) ops_q[ow_idx] <= ow_dat;
    if (nw_en) opn_q[nw_idx] <= nw_dat;
    if (pop_o) cur_q <= step_i;
    code_q <= code_d;
    rop_q  <= rop_d;
    b_q    <= b_d;
    ret_q  <= ret_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; ph_q <= 2'd0; otop_q <= '0; ntop_q <= '0;
      temp_q <= 8'd0; err_q <= 1'b0; cnt_q <= '0;
      pend_v_q <= 1'b0; out_v_q <= 1'b0; pend_q <= '0; out_q <= '0;
    end else begin
      st_q <= st_d; otop_q <= otop_d; ntop_q <= ntop_d;
      temp_q <= temp_d; err_q <= err_d;
      ph_q <= pop_o ? 2'd0 : ph_d;
      if (emit_v && cnt_q < CntW'(MaxResults)) begin
        cnt_q    <= cnt_q + 1'b1;
        pend_q   <= emit_dat;
        pend_v_q <= 1'b1;
        if (pend_v_q) out_q <= pend_q;
      end
      if ((emit_v && cnt_q < CntW'(MaxResults) && pend_v_q) || release_v) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (st_q == SEnd && st_d == SIdle) begin
        cnt_q <= '0;
        if (release_v) begin
          // eoe is the lowest bit of the packed quadruple
          out_q    <= {pend_q[$bits(quad_t)-1:1], release_eoe};
          pend_v_q <= 1'b0;
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    otop_q <= StkCw'(StackDepth) && ntop_q <= StkCw'(StackDepth))
    else $error("stack pointer past depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(MaxResults))
    else $error("result count past limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (st_q == SIdle) |-> !pend_v_q)
    else $error("held quadruple not released at end of step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SEnd && st_d == SIdle && cur_q.flush) |=> (otop_q == '0 && ntop_q == '0))
    else $error("stacks not cleared after expression end");

endmodule
